// ----- hw/rtl/tpgc_pkg.sv -----
// Package for the touch press and gesture classifier.
// Holds the beat payload types, the register codes, the controller states and the
// command and status groups shared by the controller and the datapath. No dependencies.
package tpgc_pkg;

    localparam int RAW_W   = 12;
    localparam int PRES_W  = 13;
    localparam int TIME_W  = 32;
    localparam int HOLD_W  = 16;
    localparam int POINT_W = 9;
    localparam int COORD_W = 12;
    localparam int PROD_W  = 24;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [TIME_W-1:0] GRACE_MS    = 32'd60;
    localparam logic [TIME_W-1:0] MIN_HOLD_MS = 32'd30;
    localparam logic [PRES_W-1:0] PRES_OFFSET = 13'd4095;

    localparam logic [RAW_W-1:0]  RST_X_LEFT    = 12'd3896;
    localparam logic [RAW_W-1:0]  RST_X_RIGHT   = 12'd176;
    localparam logic [RAW_W-1:0]  RST_Y_TOP     = 12'd193;
    localparam logic [RAW_W-1:0]  RST_Y_BOTTOM  = 12'd3782;
    localparam logic [2:0]        RST_ORIENT    = 3'd0;
    localparam logic [PRES_W-1:0] RST_THRESHOLD = 13'd400;
    localparam logic [HOLD_W-1:0] RST_LONG_MS   = 16'd800;
    localparam logic [HOLD_W-1:0] RST_RECAL_MS  = 16'd5000;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic [RAW_W-1:0]  pressure_a;
        logic [RAW_W-1:0]  pressure_b;
        logic [RAW_W-1:0]  x_first;
        logic [RAW_W-1:0]  x_second;
        logic [RAW_W-1:0]  y_first;
        logic [RAW_W-1:0]  y_second;
    } sample_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_TAP   = 2'd1,
        EV_LONG  = 2'd2,
        EV_RECAL = 2'd3
    } event_t;

    typedef struct packed {
        event_t             event_res;
        logic [POINT_W-1:0] point_x;
        logic [POINT_W-1:0] point_y;
        logic               is_pressed;
        logic [TIME_W-1:0]  held_ms;
        logic [PRES_W-1:0]  pressure;
    } result_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_LEFT    = 3'd0,
        CFG_X_RIGHT   = 3'd1,
        CFG_Y_TOP     = 3'd2,
        CFG_Y_BOTTOM  = 3'd3,
        CFG_ORIENT    = 3'd4,
        CFG_THRESHOLD = 3'd5,
        CFG_LONG_MS   = 3'd6,
        CFG_RECAL_MS  = 3'd7
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_LAND,
        ST_PUBLISH
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic eval;
        logic mul;
        logic div_start;
        logic div_store;
        logic land;
        logic publish;
        logic axis;
    } dp_cmd_t;

    typedef struct packed {
        logic start_press;
        logic div_done;
    } dp_status_t;

endpackage

// ----- hw/rtl/tpgc_divider.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on tpgc_pkg for the operand widths.
module tpgc_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tpgc_pkg::PROD_W-1:0] dividend,
    input  logic [tpgc_pkg::RAW_W-1:0]  divisor,
    output logic                        done,
    output logic [tpgc_pkg::PROD_W-1:0] quotient
);
    import tpgc_pkg::*;

    localparam int CNT_W = $clog2(PROD_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(PROD_W - 1);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [RAW_W-1:0]    rem_reg;
    logic [PROD_W-1:0]   quo_reg;
    logic [RAW_W-1:0]    div_reg;
    logic [RAW_W:0]      shifted;
    logic [RAW_W:0]      diff;
    logic                fits;

    assign shifted = {rem_reg, quo_reg[PROD_W-1]};
    assign diff    = shifted - {1'b0, div_reg};
    assign fits    = (shifted >= {1'b0, div_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + 1'b1;
                if (count_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[RAW_W-1:0] : shifted[RAW_W-1:0];
            quo_reg <= {quo_reg[PROD_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- hw/rtl/tpgc_datapath.sv -----
// Datapath of the classifier: configuration registers, press state, landing point
// mapping and the output register. Depends on tpgc_pkg and tpgc_divider.
module tpgc_datapath #(
    parameter int PANEL_WIDTH  = 240,
    parameter int PANEL_HEIGHT = 320,
    parameter int DEBOUNCE_MS  = 50
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tpgc_pkg::sample_t              in_data,
    output tpgc_pkg::result_t              out_data,
    input  logic                           cfg_we,
    input  logic [tpgc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tpgc_pkg::CFG_W-1:0]     cfg_data,
    input  tpgc_pkg::dp_cmd_t              cmd,
    output tpgc_pkg::dp_status_t           status
);
    import tpgc_pkg::*;

    localparam logic [COORD_W-1:0] TOP_X    = COORD_W'(PANEL_WIDTH - 1);
    localparam logic [COORD_W-1:0] TOP_Y    = COORD_W'(PANEL_HEIGHT - 1);
    localparam logic [TIME_W-1:0]  DEBOUNCE = TIME_W'(DEBOUNCE_MS);

    logic [RAW_W-1:0]   x_left_reg, x_right_reg, y_top_reg, y_bottom_reg;
    logic [2:0]         orient_reg;
    logic [PRES_W-1:0]  threshold_reg;
    logic [HOLD_W-1:0]  long_ms_reg, recal_ms_reg;

    logic               pressed_reg;
    logic [TIME_W-1:0]  press_start_reg, last_contact_reg, last_release_reg;
    logic [POINT_W-1:0] landing_x_reg, landing_y_reg;
    event_t             event_reg;

    sample_t            sample_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [RAW_W-1:0]   den_reg;
    logic               zero_reg;
    logic [COORD_W-1:0] top_reg;
    logic [COORD_W-1:0] px_reg, py_reg;
    result_t            out_reg;

    logic [PRES_W-1:0]  pres_sum;
    logic [PRES_W-1:0]  pressure;
    logic [RAW_W:0]     x_sum, y_sum;
    logic [RAW_W-1:0]   raw_x, raw_y;
    logic               touching;
    logic [TIME_W-1:0]  since_release, since_contact, held;
    logic               start_press, end_press;
    event_t             hold_class;

    logic [RAW_W-1:0]   axis_v, axis_lo, axis_hi;
    logic [COORD_W-1:0] axis_top;
    logic [RAW_W:0]     num, den;
    logic [RAW_W-1:0]   num_mag, den_mag;
    logic               div_done;
    logic [PROD_W-1:0]  quotient;
    logic [COORD_W-1:0] mapped;
    logic [COORD_W-1:0] sx, sy;

    assign pres_sum = {1'b0, sample_reg.pressure_a} + PRES_OFFSET;
    assign pressure = (pres_sum >= {1'b0, sample_reg.pressure_b})
                    ? pres_sum - {1'b0, sample_reg.pressure_b} : '0;
    assign x_sum    = {1'b0, sample_reg.x_first} + {1'b0, sample_reg.x_second};
    assign y_sum    = {1'b0, sample_reg.y_first} + {1'b0, sample_reg.y_second};
    assign raw_x    = RAW_W'(x_sum >> 1);
    assign raw_y    = RAW_W'(y_sum >> 1);

    assign touching      = (pressure >= threshold_reg);
    assign since_release = sample_reg.now_ms - last_release_reg;
    assign since_contact = sample_reg.now_ms - last_contact_reg;
    assign held          = last_contact_reg - press_start_reg;
    assign start_press   = touching && !pressed_reg && (since_release >= DEBOUNCE);
    assign end_press     = !touching && pressed_reg && (since_contact >= GRACE_MS);

    always_comb
    begin
        priority if (held < MIN_HOLD_MS)
            hold_class = EV_NONE;
        else if (held >= {16'd0, recal_ms_reg})
            hold_class = EV_RECAL;
        else if (held >= {16'd0, long_ms_reg})
            hold_class = EV_LONG;
        else
            hold_class = EV_TAP;
    end

    // The swap bit exchanges the raw axes before either is mapped.
    always_comb
    begin
        if (cmd.axis)
        begin
            axis_v   = orient_reg[2] ? raw_x : raw_y;
            axis_lo  = y_top_reg;
            axis_hi  = y_bottom_reg;
            axis_top = TOP_Y;
        end
        else
        begin
            axis_v   = orient_reg[2] ? raw_y : raw_x;
            axis_lo  = x_left_reg;
            axis_hi  = x_right_reg;
            axis_top = TOP_X;
        end
    end

    assign num     = {1'b0, axis_v} - {1'b0, axis_lo};
    assign den     = {1'b0, axis_hi} - {1'b0, axis_lo};
    assign num_mag = num[RAW_W] ? RAW_W'(-num) : num[RAW_W-1:0];
    assign den_mag = den[RAW_W] ? RAW_W'(-den) : den[RAW_W-1:0];

    tpgc_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // A quotient of the wrong sign clamps to zero; one beyond the panel edge clamps to the edge.
    always_comb
    begin
        if (zero_reg)
            mapped = '0;
        else if (quotient > {12'd0, top_reg})
            mapped = top_reg;
        else
            mapped = quotient[COORD_W-1:0];
    end

    always_comb
    begin
        unique case (orient_reg[1:0])
            2'd0:
            begin
                sx = px_reg;
                sy = py_reg;
            end
            2'd1:
            begin
                sx = py_reg;
                sy = TOP_X - px_reg;
            end
            2'd2:
            begin
                sx = TOP_X - px_reg;
                sy = TOP_Y - py_reg;
            end
            default:
            begin
                sx = TOP_Y - py_reg;
                sy = px_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_left_reg    <= RST_X_LEFT;
            x_right_reg   <= RST_X_RIGHT;
            y_top_reg     <= RST_Y_TOP;
            y_bottom_reg  <= RST_Y_BOTTOM;
            orient_reg    <= RST_ORIENT;
            threshold_reg <= RST_THRESHOLD;
            long_ms_reg   <= RST_LONG_MS;
            recal_ms_reg  <= RST_RECAL_MS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_X_LEFT:    x_left_reg    <= cfg_data[RAW_W-1:0];
                CFG_X_RIGHT:   x_right_reg   <= cfg_data[RAW_W-1:0];
                CFG_Y_TOP:     y_top_reg     <= cfg_data[RAW_W-1:0];
                CFG_Y_BOTTOM:  y_bottom_reg  <= cfg_data[RAW_W-1:0];
                CFG_ORIENT:    orient_reg    <= cfg_data[2:0];
                CFG_THRESHOLD: threshold_reg <= cfg_data[PRES_W-1:0];
                CFG_LONG_MS:   long_ms_reg   <= cfg_data[HOLD_W-1:0];
                CFG_RECAL_MS:  recal_ms_reg  <= cfg_data[HOLD_W-1:0];
                default:       orient_reg    <= orient_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg      <= 1'b0;
            press_start_reg  <= '0;
            last_contact_reg <= '0;
            last_release_reg <= '0;
            landing_x_reg    <= '0;
            landing_y_reg    <= '0;
        end
        else
        begin
            if (cmd.eval)
            begin
                if (touching)
                    last_contact_reg <= sample_reg.now_ms;
                if (start_press)
                begin
                    pressed_reg     <= 1'b1;
                    press_start_reg <= sample_reg.now_ms;
                end
                else if (end_press)
                begin
                    pressed_reg      <= 1'b0;
                    last_release_reg <= sample_reg.now_ms;
                end
            end
            if (cmd.land)
            begin
                landing_x_reg <= sx[POINT_W-1:0];
                landing_y_reg <= sy[POINT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            sample_reg <= in_data;
        if (cmd.eval)
            event_reg <= end_press ? hold_class : EV_NONE;
        if (cmd.mul)
        begin
            prod_reg <= num_mag * axis_top;
            den_reg  <= den_mag;
            zero_reg <= (num == '0) || (den == '0) || (num[RAW_W] != den[RAW_W]);
            top_reg  <= axis_top;
        end
        if (cmd.div_store)
        begin
            if (cmd.axis)
                py_reg <= mapped;
            else
                px_reg <= mapped;
        end
        if (cmd.publish)
        begin
            out_reg.event_res  <= event_reg;
            out_reg.point_x    <= landing_x_reg;
            out_reg.point_y    <= landing_y_reg;
            out_reg.is_pressed <= pressed_reg;
            out_reg.held_ms    <= pressed_reg ? sample_reg.now_ms - press_start_reg : '0;
            out_reg.pressure   <= pressure;
        end
    end

    assign status.start_press = start_press;
    assign status.div_done    = div_done;
    assign out_data           = out_reg;

endmodule

// ----- hw/rtl/tpgc_ctrl.sv -----
// Controller state machine: sequences one sample through evaluation, the two axis
// divisions of a new press and the output register. Depends on tpgc_pkg.
module tpgc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tpgc_pkg::dp_cmd_t    cmd,
    input  tpgc_pkg::dp_status_t status
);
    import tpgc_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        axis_reg, axis_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval  = 1'b1;
                axis_next = 1'b0;
                if (status.start_press)
                    state_next = ST_MUL;
                else
                    state_next = ST_PUBLISH;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV_START;
            end
            ST_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.div_store = 1'b1;
                    if (axis_reg)
                        state_next = ST_LAND;
                    else
                    begin
                        axis_next  = 1'b1;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_LAND:
            begin
                cmd.land   = 1'b1;
                state_next = ST_PUBLISH;
            end
            ST_PUBLISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.publish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- hw/rtl/touch_press_gesture_classifier.sv -----
// Top level of the touch press and gesture classifier.
// Joins tpgc_ctrl and tpgc_datapath; depends on tpgc_pkg.
//
// Each input beat is one touch sample and yields exactly one result beat. A sample that
// starts no press goes from evaluation straight to the output register; a sample that
// starts a press maps both axes, x and then y, through one shared restoring divider that
// resolves one quotient bit a cycle. A result beat that is still waiting when the next
// one is ready holds the next sample back until it is taken. One sample is in work at a
// time; the output register lets the next sample enter while a result still waits to be
// taken. Configuration writes take effect at once and belong to idle periods.
module touch_press_gesture_classifier #(
    parameter int PANEL_WIDTH  = 240,
    parameter int PANEL_HEIGHT = 320,
    parameter int DEBOUNCE_MS  = 50
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  tpgc_pkg::sample_t              in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output tpgc_pkg::result_t              out_data,
    input  logic                           cfg_we,
    input  logic [tpgc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tpgc_pkg::CFG_W-1:0]     cfg_data
);
    import tpgc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    tpgc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    tpgc_datapath #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT),
        .DEBOUNCE_MS  (DEBOUNCE_MS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ----- hw/rtl/tpgc_checker.sv -----
// Port-level checker for the classifier and the bind that attaches it to the top level.
// Depends on tpgc_pkg and touch_press_gesture_classifier.
module tpgc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input tpgc_pkg::result_t out_data
);
    import tpgc_pkg::*;

    // A result beat that is not taken stays on the port unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat dropped or changed while stalled");

    // Only one sample is in work at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second sample taken while one is in work");

    // Hold time is reported only during a press.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.is_pressed |-> out_data.held_ms == '0)
        else $error("hold time reported without a press");

    // A gesture is reported only on the beat that ends a press.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.event_res != EV_NONE |-> !out_data.is_pressed)
        else $error("gesture reported while still pressed");

endmodule

bind touch_press_gesture_classifier tpgc_checker u_tpgc_checker (.*);
